/* hdl/etp_pkg.sv */
// Shared types, constants and helper functions for the EBML track entry parser.
// No dependencies; every other file in hdl/ imports this package.
package etp_pkg;

  // Entry slots and CodecID length limit.
  localparam int MAX_TRACKS       = 8;
  localparam int CODEC_NAME_LIMIT = 32;
  localparam int TOTAL_W          = $clog2(MAX_TRACKS + 1);
  localparam int NAME_POS_W       = $clog2(CODEC_NAME_LIMIT);

  // Size vints carry at most 56 value bits; IDs at most four bytes.
  localparam int SZ_W = 56;
  localparam int ID_W = 32;

  // Result queue.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  localparam logic [ID_W-1:0] ID_TRACK_ENTRY = 32'h0000_00AE;
  localparam logic [ID_W-1:0] ID_TRACK_TYPE  = 32'h0000_0083;
  localparam logic [ID_W-1:0] ID_CODEC       = 32'h0000_0086;

  localparam logic [7:0] TYPE_VIDEO    = 8'd1;
  localparam logic [7:0] TYPE_AUDIO    = 8'd2;
  localparam logic [7:0] TYPE_SUBTITLE = 8'd17;

  localparam logic [1:0] KIND_UNSET    = 2'd0;
  localparam logic [1:0] KIND_VIDEO    = 2'd1;
  localparam logic [1:0] KIND_AUDIO    = 2'd2;
  localparam logic [1:0] KIND_SUBTITLE = 2'd3;

  localparam logic [2:0] CODEC_UNKNOWN = 3'd0;
  localparam logic [2:0] CODEC_H264    = 3'd1;
  localparam logic [2:0] CODEC_H265    = 3'd2;
  localparam logic [2:0] CODEC_AAC     = 3'd3;
  localparam logic [2:0] CODEC_OPUS    = 3'd4;
  localparam logic [2:0] CODEC_VORBIS  = 3'd5;

  localparam logic REC_TRACK   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  localparam int NUM_CODECS = 5;

  // Codec names, right-justified; character 0 is the highest non-zero byte.
  localparam logic [127:0] CODEC_TXT [NUM_CODECS] = '{
    "V_MPEG4/ISO/AVC", "V_MPEGH/ISO/HEVC", "A_AAC", "A_OPUS", {"A_", "VORBIS"}
  };
  localparam logic [4:0] CODEC_LEN [NUM_CODECS] = '{5'd15, 5'd16, 5'd5, 5'd6, 5'd8};
  localparam logic [2:0] CODEC_CODE [NUM_CODECS] = '{
    CODEC_H264, CODEC_H265, CODEC_AAC, CODEC_OPUS, CODEC_VORBIS
  };

  typedef enum logic [2:0] {
    PH_ID_FIRST,
    PH_ID_MORE,
    PH_SIZE_FIRST,
    PH_SIZE_MORE,
    PH_TOP_SKIP,
    PH_CHILD_SKIP,
    PH_TYPE_BODY,
    PH_NAME_BODY
  } etp_phase_t;

  typedef enum logic [1:0] {
    HDR_BUSY,
    HDR_DONE,
    HDR_BAD
  } etp_hdr_t;

  typedef struct packed {
    logic       record_kind;
    logic [2:0] track_index;
    logic [1:0] track_kind;
    logic [2:0] codec_code;
    logic [3:0] tracks_found;
    logic       stopped_on_error;
    logic       last_of_run;
  } etp_rec_t;

  // Results raised by one accepted byte: none, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    etp_rec_t   first;
    etp_rec_t   second;
  } etp_push_t;

  // Position of the leading one, 1 for bit 7 down to 8 for bit 0; 0 if none.
  function automatic logic [3:0] etp_lead_width(input logic [7:0] b);
    logic [3:0] w;
    w = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        w = 4'(8 - i);
      end
    end
    return w;
  endfunction

  // True if byte b is character pos of codec name c.
  function automatic logic etp_char_hit(input int c, input logic [NAME_POS_W-1:0] pos,
                                        input logic [7:0] b);
    logic [3:0] k;
    logic       hit;
    hit = 1'b0;
    k   = 4'(CODEC_LEN[c] - 5'd1) - pos[3:0];
    if (pos < NAME_POS_W'(CODEC_LEN[c])) begin
      hit = (CODEC_TXT[c][{k, 3'b000} +: 8] == b);
    end
    return hit;
  endfunction

  // First surviving name whose length equals the bytes seen; otherwise keep old code.
  function automatic logic [2:0] etp_finish(input logic [NUM_CODECS-1:0] mask,
                                            input logic [NAME_POS_W-1:0] pos,
                                            input logic [2:0] old_code);
    logic [2:0] code;
    code = old_code;
    for (int c = NUM_CODECS - 1; c >= 0; c--) begin
      if (mask[c] && pos == NAME_POS_W'(CODEC_LEN[c])) begin
        code = CODEC_CODE[c];
      end
    end
    return code;
  endfunction

endpackage

/* hdl/etp_step.sv */
// Byte-serial parse state and per-byte update for the EBML track entry parser.
// Depends on etp_pkg for phase codes, constants and the codec name table.
module etp_step import etp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output etp_push_t  push
);

  etp_phase_t                phase_r, phase_nxt;
  logic [ID_W-1:0]           id_r, id_nxt;
  logic [SZ_W-1:0]           size_r, size_nxt;
  logic [2:0]                hdr_left_r, hdr_left_nxt;
  logic [SZ_W-1:0]           entry_r, entry_nxt;
  logic [SZ_W-1:0]           payload_r, payload_nxt;
  logic                      inside_r, inside_nxt;
  logic [TOTAL_W-1:0]        total_r, total_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [2:0]                codec_r, codec_nxt;
  logic [NUM_CODECS-1:0]     mask_r, mask_nxt;
  logic [NAME_POS_W-1:0]     pos_r, pos_nxt;
  logic                      term_r, term_nxt;
  logic                      halted_r, halted_nxt;

  logic [3:0]                lw;
  etp_hdr_t                  hres;
  logic [ID_W-1:0]           hid;
  logic [SZ_W-1:0]           hsz;
  logic [2:0]                hleft;
  etp_phase_t                hphase;
  logic [SZ_W-1:0]           pl_dec;
  logic [SZ_W-1:0]           ent;
  logic [SZ_W-1:0]           opl;
  logic [NUM_CODECS-1:0]     nm_mask;
  logic [NAME_POS_W-1:0]     nm_pos;
  logic                      nm_term;
  logic                      trk;
  etp_rec_t                  trk_rec;
  etp_rec_t                  sum_rec;

  // Header byte decode, valid whenever the phase is one of the header phases.
  always_comb begin
    lw     = etp_lead_width(in_byte);
    hres   = HDR_BUSY;
    hid    = id_r;
    hsz    = size_r;
    hleft  = hdr_left_r;
    hphase = phase_r;
    case (phase_r)
      PH_ID_FIRST: begin
        if (lw == 4'd0 || lw > 4'd4) begin
          hres = HDR_BAD;
        end else begin
          hid    = ID_W'(in_byte);
          hleft  = 3'(lw - 4'd1);
          hphase = (lw > 4'd1) ? PH_ID_MORE : PH_SIZE_FIRST;
        end
      end
      PH_ID_MORE: begin
        hid   = {id_r[ID_W-9:0], in_byte};
        hleft = hdr_left_r - 3'(hdr_left_r != 3'd0);
        if (hleft == 3'd0) begin
          hphase = PH_SIZE_FIRST;
        end
      end
      PH_SIZE_FIRST: begin
        if (lw == 4'd0) begin
          hres = HDR_BAD;
        end else begin
          hsz   = SZ_W'(in_byte & (8'hFF >> lw));
          hleft = 3'(lw - 4'd1);
          if (hleft == 3'd0) begin
            hres = HDR_DONE;
          end else begin
            hphase = PH_SIZE_MORE;
          end
        end
      end
      PH_SIZE_MORE: begin
        hsz   = {size_r[SZ_W-9:0], in_byte};
        hleft = hdr_left_r - 3'(hdr_left_r != 3'd0);
        if (hleft == 3'd0) begin
          hres = HDR_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // CodecID name matching on one byte.
  always_comb begin
    nm_mask = mask_r;
    nm_pos  = pos_r;
    nm_term = term_r;
    if (!term_r) begin
      if (in_byte == 8'd0) begin
        nm_term = 1'b1;
      end else begin
        for (int c = 0; c < NUM_CODECS; c++) begin
          if (!etp_char_hit(c, pos_r, in_byte)) begin
            nm_mask[c] = 1'b0;
          end
        end
        if (pos_r != {NAME_POS_W{1'b1}}) begin
          nm_pos = pos_r + NAME_POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    size_nxt     = size_r;
    hdr_left_nxt = hdr_left_r;
    entry_nxt    = entry_r;
    payload_nxt  = payload_r;
    inside_nxt   = inside_r;
    total_nxt    = total_r;
    kind_nxt     = kind_r;
    codec_nxt    = codec_r;
    mask_nxt     = mask_r;
    pos_nxt      = pos_r;
    term_nxt     = term_r;
    halted_nxt   = halted_r;
    trk          = 1'b0;
    pl_dec       = payload_r - SZ_W'(payload_r != '0);
    ent          = entry_r - SZ_W'(entry_r != '0);
    opl          = (hsz < ent) ? hsz : ent;

    if (!halted_r) begin
      if (inside_r) begin
        entry_nxt = ent;
        case (phase_r)
          PH_CHILD_SKIP, PH_TYPE_BODY: begin
            if (phase_r == PH_TYPE_BODY) begin
              if (in_byte == TYPE_VIDEO) begin
                kind_nxt = KIND_VIDEO;
              end else if (in_byte == TYPE_AUDIO) begin
                kind_nxt = KIND_AUDIO;
              end else if (in_byte == TYPE_SUBTITLE) begin
                kind_nxt = KIND_SUBTITLE;
              end
            end
            payload_nxt = pl_dec;
            if (pl_dec == '0) begin
              phase_nxt = PH_ID_FIRST;
            end
          end
          PH_NAME_BODY: begin
            mask_nxt    = nm_mask;
            pos_nxt     = nm_pos;
            term_nxt    = nm_term;
            payload_nxt = pl_dec;
            if (pl_dec == '0) begin
              codec_nxt = etp_finish(nm_mask, nm_pos, codec_r);
              phase_nxt = PH_ID_FIRST;
            end
          end
          default: begin
            id_nxt       = hid;
            size_nxt     = hsz;
            hdr_left_nxt = hleft;
            phase_nxt    = hphase;
            if (hres == HDR_BAD) begin
              payload_nxt = ent;
              phase_nxt   = (ent != '0) ? PH_CHILD_SKIP : PH_ID_FIRST;
            end else if (hres == HDR_DONE) begin
              if (id_r == ID_TRACK_TYPE && hsz == SZ_W'(1)) begin
                phase_nxt = PH_TYPE_BODY;
              end else if (id_r == ID_CODEC && hsz < SZ_W'(CODEC_NAME_LIMIT)) begin
                phase_nxt = PH_NAME_BODY;
                mask_nxt  = '1;
                pos_nxt   = '0;
                term_nxt  = 1'b0;
              end else begin
                phase_nxt = PH_CHILD_SKIP;
              end
              payload_nxt = opl;
              // A fresh empty name matches nothing, so the codec stays as it is.
              if (opl == '0) begin
                phase_nxt = PH_ID_FIRST;
              end
            end
          end
        endcase
        if (ent == '0) begin
          trk        = 1'b1;
          inside_nxt = 1'b0;
          phase_nxt  = PH_ID_FIRST;
        end
      end else if (phase_r == PH_TOP_SKIP) begin
        payload_nxt = pl_dec;
        if (pl_dec == '0) begin
          phase_nxt = PH_ID_FIRST;
        end
      end else begin
        id_nxt       = hid;
        size_nxt     = hsz;
        hdr_left_nxt = hleft;
        phase_nxt    = hphase;
        if (hres == HDR_BAD) begin
          halted_nxt = 1'b1;
          phase_nxt  = PH_ID_FIRST;
        end else if (hres == HDR_DONE) begin
          phase_nxt = PH_ID_FIRST;
          if (id_r == ID_TRACK_ENTRY && total_r < TOTAL_W'(MAX_TRACKS)) begin
            total_nxt = total_r + TOTAL_W'(1);
            kind_nxt  = KIND_UNSET;
            codec_nxt = CODEC_UNKNOWN;
            if (hsz == '0) begin
              trk = 1'b1;
            end else begin
              inside_nxt = 1'b1;
              entry_nxt  = hsz;
            end
          end else begin
            payload_nxt = hsz;
            if (hsz != '0) begin
              phase_nxt = PH_TOP_SKIP;
            end
          end
        end
      end
    end

    // A body that ends inside an entry still reports that entry.
    if (in_last && inside_nxt && !halted_nxt) begin
      trk = 1'b1;
    end

    trk_rec.record_kind      = REC_TRACK;
    trk_rec.track_index      = (total_nxt != '0) ? 3'(total_nxt - TOTAL_W'(1)) : 3'd0;
    trk_rec.track_kind       = kind_nxt;
    trk_rec.codec_code       = codec_nxt;
    trk_rec.tracks_found     = 4'(total_nxt);
    trk_rec.stopped_on_error = 1'b0;
    trk_rec.last_of_run      = !in_last;

    sum_rec.record_kind      = REC_SUMMARY;
    sum_rec.track_index      = 3'd0;
    sum_rec.track_kind       = KIND_UNSET;
    sum_rec.codec_code       = CODEC_UNKNOWN;
    sum_rec.tracks_found     = 4'(total_nxt);
    sum_rec.stopped_on_error = halted_nxt;
    sum_rec.last_of_run      = 1'b1;

    push.first  = trk ? trk_rec : sum_rec;
    push.second = sum_rec;
    push.cnt    = in_acc ? (2'(trk) + 2'(in_last)) : 2'd0;

    // The final byte returns everything to its reset value.
    if (in_last) begin
      phase_nxt    = PH_ID_FIRST;
      id_nxt       = '0;
      size_nxt     = '0;
      hdr_left_nxt = '0;
      entry_nxt    = '0;
      payload_nxt  = '0;
      inside_nxt   = 1'b0;
      total_nxt    = '0;
      kind_nxt     = KIND_UNSET;
      codec_nxt    = CODEC_UNKNOWN;
      mask_nxt     = '1;
      pos_nxt      = '0;
      term_nxt     = 1'b0;
      halted_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ID_FIRST;
      id_r       <= '0;
      size_r     <= '0;
      hdr_left_r <= '0;
      entry_r    <= '0;
      payload_r  <= '0;
      inside_r   <= 1'b0;
      total_r    <= '0;
      kind_r     <= KIND_UNSET;
      codec_r    <= CODEC_UNKNOWN;
      mask_r     <= '1;
      pos_r      <= '0;
      term_r     <= 1'b0;
      halted_r   <= 1'b0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      id_r       <= id_nxt;
      size_r     <= size_nxt;
      hdr_left_r <= hdr_left_nxt;
      entry_r    <= entry_nxt;
      payload_r  <= payload_nxt;
      inside_r   <= inside_nxt;
      total_r    <= total_nxt;
      kind_r     <= kind_nxt;
      codec_r    <= codec_nxt;
      mask_r     <= mask_nxt;
      pos_r      <= pos_nxt;
      term_r     <= term_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // An open entry always has bytes left, and a halted stream is never inside one.
  a_entry_open: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> (entry_r != '0 && !halted_r && phase_r != PH_TOP_SKIP))
    else $error("open entry with no bytes left or in a top-level phase");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOTAL_W'(MAX_TRACKS))
    else $error("track count beyond its limit");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.first.record_kind == REC_TRACK &&
                            push.second.record_kind == REC_SUMMARY && in_last))
    else $error("two results must be a track record followed by the summary");

endmodule

/* hdl/etp_ofifo.sv */
// Small result queue: takes up to two records per cycle, hands out one.
// Depends on etp_pkg for the record type and queue depth.
module etp_ofifo import etp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  etp_push_t push,
  output logic      room,
  input  logic      pop,
  output logic      rec_valid,
  output etp_rec_t  rec
);

  etp_rec_t               mem_r [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_r, wr_nxt;
  logic [OFIFO_PTR_W-1:0] rd_r, rd_nxt;
  logic [OFIFO_CNT_W-1:0] count_r, count_nxt;
  logic                   pop_ok;

  assign rec_valid = (count_r != '0);
  assign rec       = mem_r[rd_r];
  assign room      = (count_r <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));
  assign pop_ok    = pop && rec_valid;

  always_comb begin
    wr_nxt    = wr_r + OFIFO_PTR_W'(push.cnt);
    rd_nxt    = rd_r + OFIFO_PTR_W'(pop_ok);
    count_nxt = count_r + OFIFO_CNT_W'(push.cnt) - OFIFO_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r + OFIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OFIFO_CNT_W'(OFIFO_DEPTH))
    else $error("result queue holds more than its depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("records pushed while the queue lacks room for two");

endmodule

/* hdl/ebml_track_entry_parser.sv */
// Top level of the EBML track entry parser: byte input, record output.
// Depends on etp_pkg, etp_step and etp_ofifo.
//
//  Channel | Dir | Handshake           | Contents
//  --------+-----+---------------------+--------------------------------------------
//  in_     | in  | in_tvalid/in_tready | one byte of the Tracks body, tlast on final
//  out_    | out | out_tvalid/tready   | track or summary record, tlast ends a run
//
// Each accepted byte is parsed in the cycle it is taken; the parse registers
// hold the new state at the next edge. A byte raises no, one or two records,
// which go into a four-word result queue that feeds the output port.
// The input takes a word every cycle while the queue holds two records or fewer,
// so a stalled output throttles the input only once three records back up.
// Reset (rst_n low, synchronous) returns the parser to the start of a body and
// empties the queue; the final byte of a body does the same for the parser.
module ebml_track_entry_parser import etp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] track_index, [4:3] track_kind,
                                  // [7:5] codec_code, [11:8] tracks_found,
                                  // [12] stopped_on_error, [15:13] zero
  output logic        out_tuser,  // record_kind
  output logic        out_tlast   // last_of_run
);

  etp_push_t push;
  etp_rec_t  rec;
  logic      room;
  logic      in_acc;

  // A word is taken only when the queue can absorb the worst case of two records.
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  etp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push)
  );

  etp_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .pop       (out_tready),
    .rec_valid (out_tvalid),
    .rec       (rec)
  );

  // Pack the record fields from the lowest bit up.
  assign out_tdata = {3'b000, rec.stopped_on_error, rec.tracks_found,
                      rec.codec_code, rec.track_kind, rec.track_index};
  assign out_tuser = rec.record_kind;
  assign out_tlast = rec.last_of_run;

endmodule
